// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. The bodies are empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition in the current cycle implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/rrbm_pkg.sv =====
package rrbm_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned ROM_ADDR_W  = 21;
    localparam int unsigned ROM_SW_W    = 22;
    localparam int unsigned RAM_SIZE_W  = 16;
    localparam int unsigned CFG_DATA_W  = 22;
    localparam int unsigned ROM_BANK_BYTES = 16384;

    // Configuration register indexes
    localparam logic CFG_ROM_SWITCH = 1'b0;
    localparam logic CFG_RAM_SIZE   = 1'b1;

    // Request kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Control register select (address bits 14:13 of a write below 0x8000)
    localparam logic [1:0] SEL_RAM_EN   = 2'd0;
    localparam logic [1:0] SEL_LOW_BANK = 2'd1;
    localparam logic [1:0] SEL_HIGH     = 2'd2;
    localparam logic [1:0] SEL_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [2:0] RAM_WIN_TAG  = 3'b101;   // 0xA000-0xBFFF

    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ROM       = 3'd1,
        TGT_RAM_OK    = 3'd2,
        TGT_RAM_REJ   = 3'd3,
        TGT_ROM_FAULT = 3'd4
    } target_t;

    typedef struct packed {
        logic                  operation;
        logic [ADDR_W-1:0]     address;
        logic [DATA_W-1:0]     write_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        target_t               target;
        logic [ROM_ADDR_W-1:0] rom_address;
    } out_item_t;

endpackage

// ===== src/rom_ram_bank_mapper_top.sv =====
// Cartridge bank controller.
// Input channel (in_valid/in_ready/in_data): one bus request per item, a read or
// a write with a 16-bit address and a data byte. Writes below 0x8000 update the
// RAM enable, lower ROM bank, upper bank bits and banking mode. Reads below
// 0x8000 return the physical ROM byte address (or a fault past the configured
// ROM size). Requests to 0xA000-0xBFFF read or write the internal cartridge RAM.
// Output channel (out_valid/out_ready/out_data): one result per request, in order.
// An accepted request is loaded into the decode and RAM access stage, then
// into the output register, from which its result is presented.
// Throughput: one request per cycle while the receiver does not stall, set by
// the single-port RAM which takes one read or one write a cycle.
// When the receiver stalls, the output register holds, then the decode stage
// holds, and in_ready drops; once out_ready returns both drain one per cycle.
// Reset clears the control values, loads the configuration defaults (16 KiB of
// switchable ROM, 8 KiB of RAM) and empties the pipeline. RAM contents are left
// undefined until written; no clearing pass runs. The user must write the
// configuration (cfg_we/cfg_index/cfg_data) only while idle; nothing enforces it.
module rom_ram_bank_mapper_top
    import rrbm_pkg::*;
#(
    parameter int unsigned RAM_BANK_BYTES = 8192,
    parameter int unsigned RAM_BANKS      = 4,
    parameter int unsigned ROM_ADDR_BITS  = 21
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,

    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    localparam int unsigned RAM_TOTAL = RAM_BANKS * RAM_BANK_BYTES;
    localparam int unsigned RAM_AW    = $clog2(RAM_TOTAL);
    localparam int unsigned IDX_W     = 16;
    localparam logic [ROM_ADDR_W-1:0] ROM_MASK =
        ROM_ADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
    localparam int unsigned ROM_OFF_W = $clog2(ROM_BANK_BYTES);

    // Configuration registers
    logic [ROM_SW_W-1:0]   rom_switch_reg;
    logic [RAM_SIZE_W-1:0] ram_size_reg;

    // Bank control state
    logic       ram_en_reg,   ram_en_next;
    logic [4:0] low_bank_reg, low_bank_next;
    logic [1:0] high_reg,     high_next;
    logic       mode_reg,     mode_next;

    // Decode stage and output register
    logic      s1_valid_reg;
    out_item_t s1_reg;
    logic      s1_ram_rd_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    logic      s1_move;
    logic      accept;

    // Cartridge RAM
    logic [DATA_W-1:0] cart_ram [RAM_TOTAL];
    logic [DATA_W-1:0] ram_q_reg;
    logic              ram_we;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_addr;

    // Decode results
    out_item_t       dec;
    logic            dec_ram_rd;
    logic [4:0]      lo_eff;
    logic [6:0]      rom_bank;
    logic [ROM_SW_W-1:0]   rom_off;
    logic [ROM_ADDR_W-1:0] rom_phys;
    logic [1:0]      ram_bank;
    logic [IDX_W-1:0] ram_off;
    logic [IDX_W-1:0] ram_idx;
    logic            ram_ok;

    // Handshake: the decode stage moves on whenever the output register is free
    // or being emptied; a new request enters when that stage is empty or moves on.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_move;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Switchable ROM bank: lower bank 0 stands for 1; upper bits join in ROM mode.
    assign lo_eff   = (low_bank_reg == 5'd0) ? 5'd1 : low_bank_reg;
    assign rom_bank = mode_reg ? {2'b00, lo_eff} : {high_reg, lo_eff};
    assign rom_off  = {1'b0, rom_bank - 7'd1, in_data.address[ROM_OFF_W-1:0]};
    assign rom_phys = {rom_bank, in_data.address[ROM_OFF_W-1:0]} & ROM_MASK;

    // RAM window: bank times bank size plus the offset within 0xA000-0xBFFF.
    assign ram_bank = mode_reg ? high_reg : 2'b00;
    assign ram_off  = {3'b000, in_data.address[12:0]};
    assign ram_idx  = IDX_W'(ram_bank) * IDX_W'(RAM_BANK_BYTES) + ram_off;
    assign ram_ok   = ram_en_reg
                   && (ram_off < IDX_W'(RAM_BANK_BYTES))
                   && (ram_idx < ram_size_reg)
                   && ({1'b0, ram_idx} < 17'(RAM_TOTAL));

    always_comb
    begin
        dec           = '0;
        dec.target    = TGT_NONE;
        dec_ram_rd    = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_addr      = ram_idx[RAM_AW-1:0];
        ram_en_next   = ram_en_reg;
        low_bank_next = low_bank_reg;
        high_next     = high_reg;
        mode_next     = mode_reg;

        if (!in_data.address[15]) begin
            if (in_data.operation == OP_WRITE) begin
                // Control write: pick the register by address bits 14:13
                case (in_data.address[14:13])
                    SEL_RAM_EN:   ram_en_next   = (in_data.write_data[3:0] == RAM_EN_KEY);
                    SEL_LOW_BANK: low_bank_next = in_data.write_data[4:0];
                    SEL_HIGH:     high_next     = in_data.write_data[1:0];
                    SEL_MODE:     mode_next     = in_data.write_data[0];
                    default:      mode_next     = mode_reg;
                endcase
            end
            else if (!in_data.address[14]) begin
                // Fixed bank: pass the address through
                dec.target      = TGT_ROM;
                dec.rom_address = ROM_ADDR_W'(in_data.address);
            end
            else if (rom_off >= rom_switch_reg) begin
                dec.target = TGT_ROM_FAULT;
            end
            else begin
                dec.target      = TGT_ROM;
                dec.rom_address = rom_phys;
            end
        end
        else if (in_data.address[15:13] == RAM_WIN_TAG) begin
            if (ram_ok) begin
                dec.target = TGT_RAM_OK;
                if (in_data.operation == OP_WRITE) begin
                    ram_we = accept;
                end
                else begin
                    ram_re     = accept;
                    dec_ram_rd = 1'b1;
                end
            end
            else begin
                dec.target = TGT_RAM_REJ;
            end
        end
    end

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rom_switch_reg <= ROM_SW_W'(ROM_BANK_BYTES);
            ram_size_reg   <= RAM_SIZE_W'(8192);
            ram_en_reg     <= 1'b0;
            low_bank_reg   <= 5'd0;
            high_reg       <= 2'd0;
            mode_reg       <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROM_SWITCH: rom_switch_reg <= cfg_data;
                    CFG_RAM_SIZE:   ram_size_reg   <= cfg_data[RAM_SIZE_W-1:0];
                    default:        ram_size_reg   <= ram_size_reg;
                endcase
            end
            if (accept) begin
                ram_en_reg   <= ram_en_next;
                low_bank_reg <= low_bank_next;
                high_reg     <= high_next;
                mode_reg     <= mode_next;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s1_move) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload; the RAM read word lines up with the decode stage and
    // holds while the stage is stalled, since no read issues without an accept.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_reg        <= dec;
            s1_ram_rd_reg <= dec_ram_rd;
        end
        if (s1_move) begin
            out_reg.read_data   <= s1_ram_rd_reg ? ram_q_reg : '0;
            out_reg.target      <= s1_reg.target;
            out_reg.rom_address <= s1_reg.rom_address;
        end
    end

    // Single-port RAM, one access per cycle. A write followed by a read of the
    // same byte lands on separate edges, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (ram_we) begin
            cart_ram[ram_addr] <= in_data.write_data;
        end
        if (ram_re) begin
            ram_q_reg <= cart_ram[ram_addr];
        end
    end

    // Block new requests while both stages are full and the receiver stalls
    `ASSERT_IMPLIES(a_stall_blocks, clk, rst_n,
        s1_valid_reg && out_valid_reg && !out_ready, !in_ready)
    // An accepted request always occupies the decode stage next cycle
    `ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, s1_valid_reg)
    // Only an accepted RAM access returns RAM data
    `ASSERT_IMPLIES(a_rdata_ram_only, clk, rst_n,
        out_valid_reg && (out_reg.target != TGT_RAM_OK), out_reg.read_data == '0)
    // ROM addresses appear only on ROM reads
    `ASSERT_IMPLIES(a_romaddr_rom_only, clk, rst_n,
        out_valid_reg && (out_reg.target != TGT_ROM), out_reg.rom_address == '0)

endmodule
